FILE: design/gssp_pkg.sv
// gssp_pkg: shared types, constants and move tables for the seam path search.
// Used by every module of grid_seam_shortest_path; depends on nothing.
package gssp_pkg;

   localparam int MAX_ROWS  = 64;
   localparam int MAX_COLS  = 64;
   localparam int ROW_BITS  = 6;
   localparam int COL_BITS  = 6;
   localparam int ADDR_BITS = ROW_BITS + COL_BITS;
   localparam int NPIX      = MAX_ROWS * MAX_COLS;
   localparam int DIM_BITS  = 7;
   localparam int COST_BITS = 16;
   localparam int DIST_BITS = 28;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 7;

   localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

   // item kinds
   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_RUN  = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;

   // result status
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_UNREACH = 2'd1;
   localparam logic [1:0] ST_EMPTY   = 2'd2;

   // register indexes
   localparam logic [2:0] CSR_MODE      = 3'd0;
   localparam logic [2:0] CSR_GRID_ROWS = 3'd1;
   localparam logic [2:0] CSR_GRID_COLS = 3'd2;
   localparam logic [2:0] CSR_START_ROW = 3'd3;
   localparam logic [2:0] CSR_START_COL = 3'd4;
   localparam logic [2:0] CSR_END_ROW   = 3'd5;
   localparam logic [2:0] CSR_END_COL   = 3'd6;

   localparam logic MODE_HORZ = 1'b1;

   // move codes
   localparam logic [2:0] MV_NONE = 3'd0;
   localparam logic [2:0] MV_S    = 3'd1;
   localparam logic [2:0] MV_SE   = 3'd2;
   localparam logic [2:0] MV_SW   = 3'd3;
   localparam logic [2:0] MV_E    = 3'd4;
   localparam logic [2:0] MV_W    = 3'd5;
   localparam logic [2:0] MV_N    = 3'd6;
   localparam logic [2:0] MV_NE   = 3'd7;

   localparam logic [2:0] NB_LAST = 3'd4;

   // memory write operations
   localparam logic [2:0] WR_NONE   = 3'd0;
   localparam logic [2:0] WR_LOAD   = 3'd1;
   localparam logic [2:0] WR_CLEAR  = 3'd2;
   localparam logic [2:0] WR_START  = 3'd3;
   localparam logic [2:0] WR_SETTLE = 3'd4;
   localparam logic [2:0] WR_RELAX  = 3'd5;

   // read address select
   localparam logic [1:0] RD_SCAN = 2'd0;
   localparam logic [1:0] RD_NB   = 2'd1;
   localparam logic [1:0] RD_END  = 2'd2;
   localparam logic [1:0] RD_RO   = 2'd3;

   // result register updates
   localparam logic [2:0] RSP_NONE  = 3'd0;
   localparam logic [2:0] RSP_LOAD  = 3'd1;
   localparam logic [2:0] RSP_RUN   = 3'd2;
   localparam logic [2:0] RSP_READ  = 3'd3;
   localparam logic [2:0] RSP_EMPTY = 3'd4;

   typedef struct packed {
      logic [2:0] wr_op;
      logic [1:0] rd_sel;
      logic       scan_init;
      logic       scan_issue;
      logic       nb_next;
      logic       load_wrap;
      logic       div_start;
      logic [2:0] rsp_op;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic found;
      logic nb_in;
      logic nb_last;
      logic start_in;
      logic clr_last;
      logic div_busy;
      logic ro_done;
   } ctrl_sts_type;

   function automatic logic [DIM_BITS-1:0] sat_dim(input logic [DIM_BITS-1:0] v,
                                                   input logic [DIM_BITS-1:0] lim);
      if (v == '0) return DIM_BITS'(1);
      if (v > lim) return lim;
      return v;
   endfunction

   function automatic logic [2:0] move_code(input logic mode, input logic [2:0] k);
      logic [2:0] m;
      m = MV_NONE;
      if (mode == MODE_HORZ) begin
         case (k)
            3'd0: m = MV_S;
            3'd1: m = MV_SE;
            3'd2: m = MV_E;
            3'd3: m = MV_N;
            3'd4: m = MV_NE;
            default: m = MV_NONE;
         endcase
      end else begin
         case (k)
            3'd0: m = MV_S;
            3'd1: m = MV_SE;
            3'd2: m = MV_SW;
            3'd3: m = MV_E;
            3'd4: m = MV_W;
            default: m = MV_NONE;
         endcase
      end
      return m;
   endfunction

   // row delta, sign-extended to 8 bits
   function automatic logic [7:0] move_dr(input logic [2:0] m);
      logic [7:0] d;
      case (m)
         MV_S, MV_SE, MV_SW: d = 8'd1;
         MV_N, MV_NE:        d = 8'hFF;
         default:            d = 8'd0;
      endcase
      return d;
   endfunction

   function automatic logic [7:0] move_dc(input logic [2:0] m);
      logic [7:0] d;
      case (m)
         MV_SE, MV_E, MV_NE: d = 8'd1;
         MV_SW, MV_W:        d = 8'hFF;
         default:            d = 8'd0;
      endcase
      return d;
   endfunction

endpackage

FILE: design/gssp_div.sv
// gssp_div: restoring divider, one quotient bit per cycle.
// Splits the raster load index into row and column; uses gssp_pkg.
module gssp_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [gssp_pkg::ADDR_BITS-1:0]    dividend,
   input  logic [gssp_pkg::DIM_BITS-1:0]     divisor,
   output logic                              busy,
   output logic [gssp_pkg::ADDR_BITS-1:0]    quotient,
   output logic [gssp_pkg::DIM_BITS-1:0]     remainder
);

   logic [gssp_pkg::ADDR_BITS-1:0] quo_ff, quo_in;
   logic [gssp_pkg::DIM_BITS-1:0]  rem_ff, rem_in;
   logic [3:0]                     cnt_ff, cnt_in;
   logic [gssp_pkg::DIM_BITS:0]    rem_sh;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      rem_sh = {rem_ff, quo_ff[gssp_pkg::ADDR_BITS-1]};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = 4'(gssp_pkg::ADDR_BITS);
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 4'd1;
         if (rem_sh >= {1'b0, divisor}) begin
            rem_in = gssp_pkg::DIM_BITS'(rem_sh - {1'b0, divisor});
            quo_in = {quo_ff[gssp_pkg::ADDR_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[gssp_pkg::DIM_BITS-1:0];
            quo_in = {quo_ff[gssp_pkg::ADDR_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign busy      = (cnt_ff != '0);
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: design/gssp_datapath.sv
// gssp_datapath: pixel memories, configuration registers, frontier scan,
// neighbor relaxation and result registers. Uses gssp_pkg and gssp_div.
module gssp_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [gssp_pkg::CSR_ADDR_BITS-1:0]    csr_addr,
   input  logic [gssp_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  logic                                  req_accept,
   input  logic [1:0]                            req_cmd,
   input  logic [gssp_pkg::COST_BITS-1:0]        req_cost,
   input  logic                                  req_overlap,
   input  gssp_pkg::ctrl_cmd_type                cmd,
   output gssp_pkg::ctrl_sts_type                sts,
   output logic [1:0]                            rsp_status,
   output logic [gssp_pkg::ROW_BITS-1:0]         rsp_row,
   output logic [gssp_pkg::COL_BITS-1:0]         rsp_col,
   output logic                                  rsp_last,
   output logic [gssp_pkg::DIST_BITS-1:0]        rsp_cost
);

   localparam int AW = gssp_pkg::ADDR_BITS;
   localparam int RW = gssp_pkg::ROW_BITS;
   localparam int CW = gssp_pkg::COL_BITS;
   localparam int DW = gssp_pkg::DIST_BITS;
   localparam int KW = gssp_pkg::COST_BITS;
   localparam int NW = gssp_pkg::DIM_BITS;

   // configuration
   logic          mode_ff;
   logic [NW-1:0] grid_rows_ff, grid_cols_ff;
   logic [RW-1:0] start_row_ff, end_row_ff;
   logic [CW-1:0] start_col_ff, end_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         grid_rows_ff <= NW'(64);
         grid_cols_ff <= NW'(64);
         start_row_ff <= RW'(0);
         start_col_ff <= CW'(32);
         end_row_ff   <= RW'(62);
         end_col_ff   <= CW'(32);
      end else if (csr_we) begin
         case (csr_addr)
            gssp_pkg::CSR_MODE:      mode_ff      <= csr_wdata[0];
            gssp_pkg::CSR_GRID_ROWS: grid_rows_ff <= csr_wdata;
            gssp_pkg::CSR_GRID_COLS: grid_cols_ff <= csr_wdata;
            gssp_pkg::CSR_START_ROW: start_row_ff <= csr_wdata[RW-1:0];
            gssp_pkg::CSR_START_COL: start_col_ff <= csr_wdata[CW-1:0];
            gssp_pkg::CSR_END_ROW:   end_row_ff   <= csr_wdata[RW-1:0];
            gssp_pkg::CSR_END_COL:   end_col_ff   <= csr_wdata[CW-1:0];
            default: ;
         endcase
      end
   end

   logic [NW-1:0] rows_eff, cols_eff;
   logic [AW:0]   n_pix;

   assign rows_eff = gssp_pkg::sat_dim(grid_rows_ff, NW'(gssp_pkg::MAX_ROWS));
   assign cols_eff = gssp_pkg::sat_dim(grid_cols_ff, NW'(gssp_pkg::MAX_COLS));
   assign n_pix    = (AW+1)'(rows_eff) * (AW+1)'(cols_eff);

   // latched payload
   logic [KW-1:0] cost_lat_ff;
   logic          ovl_lat_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cost_lat_ff <= req_cost;
         ovl_lat_ff  <= req_overlap;
      end
   end

   // load index and divider
   logic [AW-1:0] load_idx_ff;
   logic [AW:0]   load_next;
   logic [AW-1:0] div_q;
   logic [NW-1:0] div_r;

   assign load_next = {1'b0, load_idx_ff} + (AW+1)'(1);

   gssp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (load_idx_ff),
      .divisor   (cols_eff),
      .busy      (sts.div_busy),
      .quotient  (div_q),
      .remainder (div_r)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         load_idx_ff <= '0;
      end else if (req_accept && req_cmd == gssp_pkg::CMD_RUN) begin
         load_idx_ff <= '0;
      end else if (cmd.load_wrap) begin
         if ({1'b0, load_idx_ff} >= n_pix) load_idx_ff <= '0;
      end else if (cmd.wr_op == gssp_pkg::WR_LOAD) begin
         load_idx_ff <= (load_next >= n_pix) ? '0 : load_next[AW-1:0];
      end
   end

   // clear sweep counter
   logic [AW-1:0] clr_ff;

   always_ff @(posedge clock) begin
      if (reset || req_accept) begin
         clr_ff <= '0;
      end else if (cmd.wr_op == gssp_pkg::WR_CLEAR) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   assign sts.clr_last = (clr_ff == {AW{1'b1}});
   assign sts.start_in = ({1'b0, start_row_ff} < rows_eff) &&
                         ({1'b0, start_col_ff} < cols_eff);

   // frontier scan
   logic [RW-1:0] sr_ff, p_r_ff, br_ff;
   logic [CW-1:0] sc_ff, p_c_ff, bc_ff;
   logic          p_valid_ff, found_ff;
   logic [DW-1:0] best_ff;
   logic          sc_end;

   // memory read data
   logic [KW-1:0] cost_q;
   logic          ovl_q, vis_q, fr_q;
   logic [DW-1:0] dist_q;
   logic [2:0]    par_q;

   assign sc_end        = ({1'b0, sc_ff} == cols_eff - NW'(1));
   assign sts.scan_last = sc_end && ({1'b0, sr_ff} == rows_eff - NW'(1));
   assign sts.found     = found_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         found_ff   <= 1'b0;
      end else begin
         p_valid_ff <= cmd.scan_issue;
         if (cmd.scan_init) begin
            found_ff <= 1'b0;
         end else if (p_valid_ff && fr_q && (!found_ff || dist_q < best_ff)) begin
            found_ff <= 1'b1;
         end
      end
      if (cmd.scan_init) begin
         sr_ff <= '0;
         sc_ff <= '0;
      end else if (cmd.scan_issue) begin
         if (sc_end) begin
            sc_ff <= '0;
            sr_ff <= sr_ff + RW'(1);
         end else begin
            sc_ff <= sc_ff + CW'(1);
         end
      end
      p_r_ff <= sr_ff;
      p_c_ff <= sc_ff;
      if (!cmd.scan_init && p_valid_ff && fr_q && (!found_ff || dist_q < best_ff)) begin
         best_ff <= dist_q;
         br_ff   <= p_r_ff;
         bc_ff   <= p_c_ff;
      end
   end

   // neighbor walk
   logic [2:0] k_ff;
   logic [2:0] nb_move;
   logic [7:0] nr, nc;

   assign nb_move     = gssp_pkg::move_code(mode_ff, k_ff);
   assign nr          = {2'b00, br_ff} + gssp_pkg::move_dr(nb_move);
   assign nc          = {2'b00, bc_ff} + gssp_pkg::move_dc(nb_move);
   assign sts.nb_in   = !nr[7] && !nc[7] && (nr[NW-1:0] < rows_eff) && (nc[NW-1:0] < cols_eff);
   assign sts.nb_last = (k_ff == gssp_pkg::NB_LAST);

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         k_ff <= '0;
      end else if (cmd.nb_next) begin
         k_ff <= k_ff + 3'd1;
      end
   end

   logic [DW:0]   sum;
   logic [DW-1:0] relax_d;
   logic          relax_ok;

   assign sum      = {1'b0, best_ff} + (DW+1)'(cost_q);
   assign relax_d  = (sum > {1'b0, gssp_pkg::DIST_MAX}) ? gssp_pkg::DIST_MAX : sum[DW-1:0];
   assign relax_ok = !vis_q && ovl_q && (relax_d < dist_q);

   // readout walker
   logic [RW-1:0] ro_row_ff;
   logic [CW-1:0] ro_col_ff;
   logic          ro_done_ff;
   logic [7:0]    pr, pc;

   assign pr          = {2'b00, ro_row_ff} - gssp_pkg::move_dr(par_q);
   assign pc          = {2'b00, ro_col_ff} - gssp_pkg::move_dc(par_q);
   assign sts.ro_done = ro_done_ff;

   // addresses
   logic [AW-1:0] rd_addr, wr_addr;
   logic          end_in;

   assign end_in = ({1'b0, end_row_ff} < rows_eff) && ({1'b0, end_col_ff} < cols_eff);

   always_comb begin
      case (cmd.rd_sel)
         gssp_pkg::RD_SCAN: rd_addr = {sr_ff, sc_ff};
         gssp_pkg::RD_NB:   rd_addr = {nr[RW-1:0], nc[CW-1:0]};
         gssp_pkg::RD_END:  rd_addr = {end_row_ff, end_col_ff};
         gssp_pkg::RD_RO:   rd_addr = {ro_row_ff, ro_col_ff};
         default:           rd_addr = {sr_ff, sc_ff};
      endcase
   end

   logic we_cost, we_dist, we_par, we_vis, we_fr;
   logic [DW-1:0] wd_dist;
   logic [2:0]    wd_par;
   logic          wd_vis, wd_fr;

   always_comb begin
      we_cost = 1'b0;
      we_dist = 1'b0;
      we_par  = 1'b0;
      we_vis  = 1'b0;
      we_fr   = 1'b0;
      wd_dist = gssp_pkg::DIST_MAX;
      wd_par  = gssp_pkg::MV_NONE;
      wd_vis  = 1'b0;
      wd_fr   = 1'b0;
      wr_addr = clr_ff;
      case (cmd.wr_op)
         gssp_pkg::WR_LOAD: begin
            we_cost = 1'b1;
            wr_addr = {div_q[RW-1:0], div_r[CW-1:0]};
         end
         gssp_pkg::WR_CLEAR: begin
            we_dist = 1'b1;
            we_vis  = 1'b1;
            we_fr   = 1'b1;
         end
         gssp_pkg::WR_START: begin
            we_dist = 1'b1;
            we_par  = 1'b1;
            we_fr   = 1'b1;
            wd_dist = '0;
            wd_fr   = 1'b1;
            wr_addr = {start_row_ff, start_col_ff};
         end
         gssp_pkg::WR_SETTLE: begin
            we_vis  = 1'b1;
            we_fr   = 1'b1;
            wd_vis  = 1'b1;
            wr_addr = {br_ff, bc_ff};
         end
         gssp_pkg::WR_RELAX: begin
            we_dist = relax_ok;
            we_par  = relax_ok;
            we_fr   = relax_ok;
            wd_dist = relax_d;
            wd_par  = nb_move;
            wd_fr   = 1'b1;
            wr_addr = {nr[RW-1:0], nc[CW-1:0]};
         end
         default: ;
      endcase
   end

   // pixel memories
   logic [KW-1:0] cost_mem [gssp_pkg::NPIX];
   logic          ovl_mem  [gssp_pkg::NPIX];
   logic [DW-1:0] dist_mem [gssp_pkg::NPIX];
   logic [2:0]    par_mem  [gssp_pkg::NPIX];
   logic          vis_mem  [gssp_pkg::NPIX];
   logic          fr_mem   [gssp_pkg::NPIX];

   always_ff @(posedge clock) begin
      if (we_cost) begin
         cost_mem[wr_addr] <= cost_lat_ff;
         ovl_mem[wr_addr]  <= ovl_lat_ff;
      end
      if (we_dist) dist_mem[wr_addr] <= wd_dist;
      if (we_par)  par_mem[wr_addr]  <= wd_par;
      if (we_vis)  vis_mem[wr_addr]  <= wd_vis;
      if (we_fr)   fr_mem[wr_addr]   <= wd_fr;
      cost_q <= cost_mem[rd_addr];
      ovl_q  <= ovl_mem[rd_addr];
      dist_q <= dist_mem[rd_addr];
      par_q  <= par_mem[rd_addr];
      vis_q  <= vis_mem[rd_addr];
      fr_q   <= fr_mem[rd_addr];
   end

   // result registers and readout state
   logic run_ok;

   assign run_ok = end_in && vis_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         ro_done_ff <= 1'b1;
         ro_row_ff  <= '0;
         ro_col_ff  <= '0;
      end else begin
         case (cmd.rsp_op)
            gssp_pkg::RSP_RUN: begin
               ro_row_ff  <= end_row_ff;
               ro_col_ff  <= end_col_ff;
               ro_done_ff <= !run_ok;
            end
            gssp_pkg::RSP_READ: begin
               if (par_q == gssp_pkg::MV_NONE || pr[7] || pr[6] || pc[7] || pc[6]) begin
                  ro_done_ff <= 1'b1;
               end else begin
                  ro_row_ff <= pr[RW-1:0];
                  ro_col_ff <= pc[CW-1:0];
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.rsp_op)
         gssp_pkg::RSP_LOAD: begin
            rsp_status <= gssp_pkg::ST_OK;
            rsp_row    <= '0;
            rsp_col    <= '0;
            rsp_last   <= 1'b0;
            rsp_cost   <= '0;
         end
         gssp_pkg::RSP_RUN: begin
            rsp_status <= run_ok ? gssp_pkg::ST_OK : gssp_pkg::ST_UNREACH;
            rsp_row    <= end_row_ff;
            rsp_col    <= end_col_ff;
            rsp_last   <= 1'b0;
            rsp_cost   <= run_ok ? dist_q : gssp_pkg::DIST_MAX;
         end
         gssp_pkg::RSP_READ: begin
            rsp_status <= gssp_pkg::ST_OK;
            rsp_row    <= ro_row_ff;
            rsp_col    <= ro_col_ff;
            rsp_last   <= (par_q == gssp_pkg::MV_NONE);
            rsp_cost   <= dist_q;
         end
         gssp_pkg::RSP_EMPTY: begin
            rsp_status <= gssp_pkg::ST_EMPTY;
            rsp_row    <= '0;
            rsp_col    <= '0;
            rsp_last   <= 1'b0;
            rsp_cost   <= '0;
         end
         default: ;
      endcase
   end

endmodule

FILE: design/gssp_ctrl.sv
// gssp_ctrl: sequencer for load, run (clear, scan, settle, relax) and readout.
// Drives gssp_datapath through command/status structs from gssp_pkg.
module gssp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [1:0]              req_cmd,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  gssp_pkg::ctrl_sts_type  sts,
   output gssp_pkg::ctrl_cmd_type  cmd
);

   localparam logic [4:0] S_IDLE       = 5'd0;
   localparam logic [4:0] S_LOAD_WRAP  = 5'd1;
   localparam logic [4:0] S_LOAD_DIV   = 5'd2;
   localparam logic [4:0] S_LOAD_WAIT  = 5'd3;
   localparam logic [4:0] S_LOAD_WR    = 5'd4;
   localparam logic [4:0] S_CLEAR      = 5'd5;
   localparam logic [4:0] S_START      = 5'd6;
   localparam logic [4:0] S_SCAN_INIT  = 5'd7;
   localparam logic [4:0] S_SCAN       = 5'd8;
   localparam logic [4:0] S_SCAN_DRAIN = 5'd9;
   localparam logic [4:0] S_DECIDE     = 5'd10;
   localparam logic [4:0] S_SETTLE     = 5'd11;
   localparam logic [4:0] S_NB_RD      = 5'd12;
   localparam logic [4:0] S_NB_WR      = 5'd13;
   localparam logic [4:0] S_FIN_RD     = 5'd14;
   localparam logic [4:0] S_FIN_OUT    = 5'd15;
   localparam logic [4:0] S_RD_ISSUE   = 5'd16;
   localparam logic [4:0] S_RD_OUT     = 5'd17;
   localparam logic [4:0] S_RESP       = 5'd18;

   logic [4:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.wr_op      = gssp_pkg::WR_NONE;
      cmd.rd_sel     = gssp_pkg::RD_SCAN;
      cmd.rsp_op     = gssp_pkg::RSP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  gssp_pkg::CMD_LOAD: state_in = S_LOAD_WRAP;
                  gssp_pkg::CMD_RUN:  state_in = S_CLEAR;
                  gssp_pkg::CMD_READ: state_in = S_RD_ISSUE;
                  default: begin
                     cmd.rsp_op = gssp_pkg::RSP_EMPTY;
                     state_in   = S_RESP;
                  end
               endcase
            end
         end
         S_LOAD_WRAP: begin
            cmd.load_wrap = 1'b1;
            state_in      = S_LOAD_DIV;
         end
         S_LOAD_DIV: begin
            cmd.div_start = 1'b1;
            state_in      = S_LOAD_WAIT;
         end
         S_LOAD_WAIT: begin
            if (!sts.div_busy) state_in = S_LOAD_WR;
         end
         S_LOAD_WR: begin
            cmd.wr_op  = gssp_pkg::WR_LOAD;
            cmd.rsp_op = gssp_pkg::RSP_LOAD;
            state_in   = S_RESP;
         end
         S_CLEAR: begin
            cmd.wr_op = gssp_pkg::WR_CLEAR;
            if (sts.clr_last) state_in = S_START;
         end
         S_START: begin
            if (sts.start_in) begin
               cmd.wr_op = gssp_pkg::WR_START;
               state_in  = S_SCAN_INIT;
            end else begin
               state_in  = S_FIN_RD;
            end
         end
         S_SCAN_INIT: begin
            cmd.scan_init = 1'b1;
            state_in      = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_issue = 1'b1;
            cmd.rd_sel     = gssp_pkg::RD_SCAN;
            if (sts.scan_last) state_in = S_SCAN_DRAIN;
         end
         S_SCAN_DRAIN: state_in = S_DECIDE;
         S_DECIDE: state_in = sts.found ? S_SETTLE : S_FIN_RD;
         S_SETTLE: begin
            cmd.wr_op = gssp_pkg::WR_SETTLE;
            state_in  = S_NB_RD;
         end
         S_NB_RD: begin
            cmd.rd_sel = gssp_pkg::RD_NB;
            if (sts.nb_in) begin
               state_in = S_NB_WR;
            end else begin
               cmd.nb_next = 1'b1;
               if (sts.nb_last) state_in = S_SCAN_INIT;
            end
         end
         S_NB_WR: begin
            cmd.rd_sel  = gssp_pkg::RD_NB;
            cmd.wr_op   = gssp_pkg::WR_RELAX;
            cmd.nb_next = 1'b1;
            state_in    = sts.nb_last ? S_SCAN_INIT : S_NB_RD;
         end
         S_FIN_RD: begin
            cmd.rd_sel = gssp_pkg::RD_END;
            state_in   = S_FIN_OUT;
         end
         S_FIN_OUT: begin
            cmd.rsp_op = gssp_pkg::RSP_RUN;
            state_in   = S_RESP;
         end
         S_RD_ISSUE: begin
            cmd.rd_sel = gssp_pkg::RD_RO;
            if (sts.ro_done) begin
               cmd.rsp_op = gssp_pkg::RSP_EMPTY;
               state_in   = S_RESP;
            end else begin
               state_in   = S_RD_OUT;
            end
         end
         S_RD_OUT: begin
            cmd.rsp_op = gssp_pkg::RSP_READ;
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (valid_ff && rsp_tready) valid_in = 1'b0;
      if (cmd.rsp_op != gssp_pkg::RSP_NONE) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   // the result register is only loaded while no earlier result is pending
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_op != gssp_pkg::RSP_NONE) |-> !valid_ff)
      else $error("result register loaded while a result is pending");

   // a started division always reports busy on the next cycle
   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> sts.div_busy)
      else $error("divider did not start");

   // an empty frontier ends the search
   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && !sts.found) |=> (state_ff == S_FIN_RD))
      else $error("search continued with an empty frontier");

   // a valid result is only shown from the response wait state
   a_valid_in_resp: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (state_ff == S_RESP))
      else $error("result valid outside response state");

endmodule

FILE: design/grid_seam_shortest_path.sv
// grid_seam_shortest_path: top level of the minimum-cost seam search.
// Joins gssp_ctrl and gssp_datapath; types and constants from gssp_pkg.
//
//  channel  | direction | transfer when         | payload
//  ---------+-----------+-----------------------+-----------------------------------------
//  req_*    | in        | req_tvalid&req_tready | tuser=cmd, tdata=cost,in_overlap
//  rsp_*    | out       | rsp_tvalid&rsp_tready | tuser=status, tdata=row,col,cost, tlast
//  csr_*    | in        | csr_we                | csr_addr=register index, csr_wdata=value
//
// One item at a time: req_tready is high only while the sequencer is idle.
// Load: the bit-serial divider splits the raster index into row and column.
// Run: a clearing pass over all 4096 pixel-memory entries, then per settled pixel
//   one frontier scan over rows*cols pixels (one memory read per cycle) plus a
//   settle and neighbor relax step.
// Reset (synchronous, active high) clears control state and restores registers.
// A result stalls in its output register until taken; no new request meanwhile.
module grid_seam_shortest_path (
   input  logic                                clock,
   input  logic                                reset,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [23:0]                         req_tdata,  // [15:0] cost, [16] in_overlap
   input  logic [1:0]                          req_tuser,  // [1:0] cmd
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [39:0]                         rsp_tdata,  // [5:0] path_row, [11:6] path_col,
                                                           // [39:12] path_cost
   output logic [1:0]                          rsp_tuser,  // [1:0] status
   output logic                                rsp_tlast,  // path_last
   // configuration writes
   input  logic                                csr_we,
   input  logic [gssp_pkg::CSR_ADDR_BITS-1:0]  csr_addr,
   input  logic [gssp_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   gssp_pkg::ctrl_cmd_type cmd;
   gssp_pkg::ctrl_sts_type sts;

   logic [gssp_pkg::ROW_BITS-1:0]  rsp_row;
   logic [gssp_pkg::COL_BITS-1:0]  rsp_col;
   logic [gssp_pkg::DIST_BITS-1:0] rsp_cost;

   gssp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   gssp_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .req_accept  (req_tvalid && req_tready),
      .req_cmd     (req_tuser),
      .req_cost    (req_tdata[15:0]),
      .req_overlap (req_tdata[16]),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_status  (rsp_tuser),
      .rsp_row     (rsp_row),
      .rsp_col     (rsp_col),
      .rsp_last    (rsp_tlast),
      .rsp_cost    (rsp_cost)
   );

   // pack result fields, lowest field first
   assign rsp_tdata = {rsp_cost, rsp_col, rsp_row};

endmodule
